// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
        return (pos == PTR_LAST) ? '0 : pos + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] pos);
        return (pos == '0) ? PTR_LAST : pos - PTR_W'(1);
    endfunction

endpackage

// ===== hw/rtl/deq_ram.sv =====
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// The accepting edge moves the control from S_IDLE into S_FETCH; the result strobe
// and the result words are registered at the edge that leaves S_FETCH.
// A new command is taken only in S_IDLE; busy is high for the one cycle in
// which the slot memory's registered read port returns the new end word.
// Reset (synchronous, active low) empties the deque; slot contents are kept.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_cmd,
    input  logic signed [WORD_W-1:0] i_data_value,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_rear_word,
    output logic                    o_is_empty,
    output logic [CNT_W-1:0]        o_occupancy
);

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [WORD_W-1:0]  r_front, n_front;
    logic [WORD_W-1:0]  r_rear, n_rear;
    logic               r_fill_front, n_fill_front;
    logic               r_fill_rear, n_fill_rear;
    logic [1:0]         r_status, n_status;

    logic               r_valid, n_valid;
    logic [1:0]         r_o_status, n_o_status;
    logic [WORD_W-1:0]  r_o_front, n_o_front;
    logic [WORD_W-1:0]  r_o_rear, n_o_rear;
    logic               r_o_empty, n_o_empty;
    logic [CNT_W-1:0]   r_o_count, n_o_count;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [PTR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_rear       = r_rear;
        n_fill_front = r_fill_front;
        n_fill_rear  = r_fill_rear;
        n_status     = r_status;
        n_valid      = 1'b0;
        n_o_status   = r_o_status;
        n_o_front    = r_o_front;
        n_o_rear     = r_o_rear;
        n_o_empty    = r_o_empty;
        n_o_count    = r_o_count;
        ram_we       = 1'b0;
        ram_waddr    = ring_prev(r_head);
        ram_raddr    = ring_next(r_head);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state      = S_FETCH;
                    n_status     = ST_DONE;
                    n_fill_front = 1'b0;
                    n_fill_rear  = 1'b0;
                    unique case (i_cmd)
                        CMD_PUSH_FRONT: begin
                            if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = ring_prev(r_head);
                                n_head    = ring_prev(r_head);
                                n_count   = r_count + CNT_W'(1);
                                n_front   = i_data_value;
                                if (r_count == '0) begin
                                    n_rear = i_data_value;
                                end
                            end
                        end
                        CMD_PUSH_REAR: begin
                            if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_tail;
                                n_tail    = ring_next(r_tail);
                                n_count   = r_count + CNT_W'(1);
                                n_rear    = i_data_value;
                                if (r_count == '0) begin
                                    n_front = i_data_value;
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // The new front sits at the advanced head.
                                ram_raddr    = ring_next(r_head);
                                n_head       = ring_next(r_head);
                                n_count      = r_count - CNT_W'(1);
                                n_fill_front = 1'b1;
                            end
                        end
                        CMD_POP_REAR: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // The new rear sits one before the retreated tail.
                                ram_raddr   = ring_prev(ring_prev(r_tail));
                                n_tail      = ring_prev(r_tail);
                                n_count     = r_count - CNT_W'(1);
                                n_fill_rear = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state = S_IDLE;
                if (r_fill_front) begin
                    n_front = ram_rdata;
                end
                if (r_fill_rear) begin
                    n_rear = ram_rdata;
                end
                n_valid    = 1'b1;
                n_o_status = r_status;
                n_o_empty  = (r_count == '0);
                n_o_count  = r_count;
                if (r_count == '0) begin
                    n_o_front = '1;
                    n_o_rear  = '1;
                end else begin
                    n_o_front = r_fill_front ? ram_rdata : r_front;
                    n_o_rear  = r_fill_rear ? ram_rdata : r_rear;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_rear       <= n_rear;
        r_fill_front <= n_fill_front;
        r_fill_rear  <= n_fill_rear;
        r_status     <= n_status;
        r_o_status   <= n_o_status;
        r_o_front    <= n_o_front;
        r_o_rear     <= n_o_rear;
        r_o_empty    <= n_o_empty;
        r_o_count    <= n_o_count;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_o_status;
    assign o_front_word = r_o_front;
    assign o_rear_word  = r_o_rear;
    assign o_is_empty   = r_o_empty;
    assign o_occupancy  = r_o_count;

endmodule

// ===== sim/deque_checker.sv =====
`timescale 1ns / 1ps

module deque_checker
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_busy,
    input  logic [1:0]               i_cmd,
    input  logic signed [WORD_W-1:0] i_data_value,
    input  logic                     i_valid,
    input  logic [1:0]               i_status,
    input  logic signed [WORD_W-1:0] i_front_word,
    input  logic signed [WORD_W-1:0] i_rear_word,
    input  logic                     i_is_empty,
    input  logic [CNT_W-1:0]         i_occupancy,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] front_word;
        logic [WORD_W-1:0] rear_word;
        logic              is_empty;
        logic [CNT_W-1:0]  occupancy;
    } t_deq_result;

    logic [WORD_W-1:0] ring_words [DEPTH];
    int                head_pos;
    int                tail_pos;
    int                held;
    int                mismatches = 0;
    t_deq_result       awaited_results [$];

    assign o_fail_count = mismatches;

    // Apply one operation to the shadow deque and return the result it must produce.
    function automatic t_deq_result apply_op(input logic [1:0] cmd,
                                             input logic [WORD_W-1:0] word);
        t_deq_result res;
        res.status = ST_DONE;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
            if (held >= DEPTH) begin
                res.status = ST_FULL;
            end else if (cmd == CMD_PUSH_FRONT) begin
                head_pos = (head_pos + DEPTH - 1) % DEPTH;
                ring_words[PTR_W'(head_pos)] = word;
                held++;
            end else begin
                ring_words[PTR_W'(tail_pos)] = word;
                tail_pos = (tail_pos + 1) % DEPTH;
                held++;
            end
        end else begin
            if (held == 0) begin
                res.status = ST_EMPTY;
            end else if (cmd == CMD_POP_FRONT) begin
                head_pos = (head_pos + 1) % DEPTH;
                held--;
            end else begin
                tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
                held--;
            end
        end
        if (held != 0) begin
            res.front_word = ring_words[PTR_W'(head_pos)];
            res.rear_word  = ring_words[PTR_W'((tail_pos + DEPTH - 1) % DEPTH)];
        end else begin
            res.front_word = '1;
            res.rear_word  = '1;
        end
        res.is_empty  = (held == 0);
        res.occupancy = CNT_W'(held);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    // Inputs are sampled at the edge before the testbench and the block update them.
    always @(posedge i_clk) begin
        t_deq_result want;
        if (!i_rst_n) begin
            head_pos = 0;
            tail_pos = 0;
            held     = 0;
            awaited_results.delete();
            o_pending <= 0;
        end else begin
            if (i_start && !i_busy) begin
                awaited_results.push_back(apply_op(i_cmd, i_data_value));
            end
            if (i_valid) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual status %0d",
                             $time, i_status);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", WORD_W'(want.status), WORD_W'(i_status));
                    check_field("front_word", want.front_word, i_front_word);
                    check_field("rear_word", want.rear_word, i_rear_word);
                    check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(i_is_empty));
                    check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(i_occupancy));
                end
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import deq_pkg::*;

    localparam int ITEM_TARGET = 2000;
    localparam int CYCLE_LIMIT = 200000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_cmd;
    logic signed [WORD_W-1:0] i_data_value;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic signed [WORD_W-1:0] o_front_word;
    logic signed [WORD_W-1:0] o_rear_word;
    logic                     o_is_empty;
    logic [CNT_W-1:0]         o_occupancy;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;
    int                       items_sent = 0;
    int                       burst_left = 0;

    always #4 i_clk = ~i_clk;

    double_ended_queue i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_data_value (i_data_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_front_word (o_front_word),
        .o_rear_word  (o_rear_word),
        .o_is_empty   (o_is_empty),
        .o_occupancy  (o_occupancy)
    );

    deque_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_data_value (i_data_value),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_front_word (o_front_word),
        .i_rear_word  (o_rear_word),
        .i_is_empty   (o_is_empty),
        .i_occupancy  (o_occupancy),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_push();
        return $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    endfunction

    function automatic logic [1:0] pick_pop();
        return $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
    endfunction

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Start stays high through a burst; a gap of random length opens the next one in three cases of four.
    task automatic send(input logic [1:0] cmd, input logic [WORD_W-1:0] word);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                pause($urandom_range(1, 6));
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        start        <= 1'b1;
        i_cmd        <= cmd;
        i_data_value <= word;
        do @(posedge i_clk); while (busy);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int  round_len;
        int  push_pct;
        logic [1:0] cmd;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_cmd        <= CMD_PUSH_FRONT;
        i_data_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Refused pops on an empty deque, pushes of the extreme words at both ends, then pops at both ends past empty.
        send(CMD_POP_FRONT, 32'h1234_5678);
        send(CMD_POP_REAR, '1);
        send(CMD_PUSH_FRONT, 32'h7fff_ffff);
        send(CMD_PUSH_REAR, 32'h8000_0000);
        send(CMD_PUSH_FRONT, '1);
        send(CMD_PUSH_REAR, '0);
        send(CMD_POP_FRONT, '0);
        send(CMD_POP_REAR, '0);
        send(CMD_POP_REAR, '1);
        send(CMD_POP_FRONT, '1);
        send(CMD_POP_FRONT, 32'h5555_5555);
        send(CMD_PUSH_REAR, 32'h5555_5555);
        send(CMD_PUSH_FRONT, 32'haaaa_aaaa);
        send(CMD_POP_REAR, '0);
        send(CMD_POP_REAR, '0);
        send(CMD_POP_REAR, '0);
        wait_drained();

        // Fill past full so pushes are refused, then drain past empty.
        repeat (DEPTH + 6) send(pick_push(), pick_word());
        repeat (DEPTH + 6) send(pick_pop(), pick_word());
        wait_drained();

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            round_len = $urandom_range(10, 120);
            repeat (round_len) begin
                cmd = ($urandom_range(0, 99) < push_pct) ? pick_push() : pick_pop();
                send(cmd, pick_word());
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/double_ended_queue.sv
sim/deque_checker.sv
sim/testbench.sv
